/* rtl/tovl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tovl_pkg: text overlay shared types and constants
// Beat structs, register indexes, string placement and the 5x7 column font.
// ----------------------------------------------------------------------------
package tovl_pkg;

    typedef struct packed {
        logic [11:0] x_position;
        logic [11:0] y_position;
    } t_pixel_in;

    typedef struct packed {
        logic [15:0] pixel_color;
        logic        is_text;
    } t_pixel_out;

    // Register indexes on the configuration port
    localparam logic [2:0] CFG_BACKGROUND_COLOR = 3'd0;
    localparam logic [2:0] CFG_CODE_TEXT        = 3'd1;
    localparam logic [2:0] CFG_CODE_LENGTH      = 3'd2;
    localparam logic [2:0] CFG_DETAIL_TEXT_LOW  = 3'd3;
    localparam logic [2:0] CFG_DETAIL_TEXT_HIGH = 3'd4;
    localparam logic [2:0] CFG_DETAIL_LENGTH    = 3'd5;

    // String placement; scales are powers of two, given as log2
    localparam int CODE_LEFT         = 32;
    localparam int CODE_TOP          = 80;
    localparam int CODE_SCALE_LOG2   = 2;
    localparam int DETAIL_LEFT       = 32;
    localparam int DETAIL_TOP        = 160;
    localparam int DETAIL_SCALE_LOG2 = 1;

    localparam logic [15:0] FG_DARK      = 16'h0000;
    localparam logic [15:0] FG_LIGHT     = 16'hffff;
    localparam logic [6:0]  BRIGHT_LIMIT = 7'd63;

    // Five columns, column 0 first; bit 0 of a column is the top row
    typedef logic [0:4][6:0] t_glyph;

    function automatic t_glyph glyph_lookup(input logic [7:0] ch);
        logic [7:0] up;
        t_glyph     g;
        // fold lower case to upper case
        up = (ch >= 8'h61 && ch <= 8'h7a) ? (ch - 8'h20) : ch;
        unique case (up)
            8'h30: g = {7'h3e, 7'h51, 7'h49, 7'h45, 7'h3e};
            8'h31: g = {7'h00, 7'h42, 7'h7f, 7'h40, 7'h00};
            8'h32: g = {7'h42, 7'h61, 7'h51, 7'h49, 7'h46};
            8'h33: g = {7'h21, 7'h41, 7'h45, 7'h4b, 7'h31};
            8'h34: g = {7'h18, 7'h14, 7'h12, 7'h7f, 7'h10};
            8'h35: g = {7'h27, 7'h45, 7'h45, 7'h45, 7'h39};
            8'h36: g = {7'h3c, 7'h4a, 7'h49, 7'h49, 7'h30};
            8'h37: g = {7'h01, 7'h71, 7'h09, 7'h05, 7'h03};
            8'h38: g = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
            8'h39: g = {7'h06, 7'h49, 7'h49, 7'h29, 7'h1e};
            8'h41: g = {7'h7e, 7'h11, 7'h11, 7'h11, 7'h7e};
            8'h42: g = {7'h7f, 7'h49, 7'h49, 7'h49, 7'h36};
            8'h43: g = {7'h3e, 7'h41, 7'h41, 7'h41, 7'h22};
            8'h44: g = {7'h7f, 7'h41, 7'h41, 7'h22, 7'h1c};
            8'h45: g = {7'h7f, 7'h49, 7'h49, 7'h49, 7'h41};
            8'h46: g = {7'h7f, 7'h09, 7'h09, 7'h09, 7'h01};
            8'h47: g = {7'h3e, 7'h41, 7'h49, 7'h49, 7'h7a};
            8'h48: g = {7'h7f, 7'h08, 7'h08, 7'h08, 7'h7f};
            8'h49: g = {7'h00, 7'h41, 7'h7f, 7'h41, 7'h00};
            8'h4a: g = {7'h20, 7'h40, 7'h41, 7'h3f, 7'h01};
            8'h4b: g = {7'h7f, 7'h08, 7'h14, 7'h22, 7'h41};
            8'h4c: g = {7'h7f, 7'h40, 7'h40, 7'h40, 7'h40};
            8'h4d: g = {7'h7f, 7'h02, 7'h0c, 7'h02, 7'h7f};
            8'h4e: g = {7'h7f, 7'h04, 7'h08, 7'h10, 7'h7f};
            8'h4f: g = {7'h3e, 7'h41, 7'h41, 7'h41, 7'h3e};
            8'h50: g = {7'h7f, 7'h09, 7'h09, 7'h09, 7'h06};
            8'h51: g = {7'h3e, 7'h41, 7'h51, 7'h21, 7'h5e};
            8'h52: g = {7'h7f, 7'h09, 7'h19, 7'h29, 7'h46};
            8'h53: g = {7'h46, 7'h49, 7'h49, 7'h49, 7'h31};
            8'h54: g = {7'h01, 7'h01, 7'h7f, 7'h01, 7'h01};
            8'h55: g = {7'h3f, 7'h40, 7'h40, 7'h40, 7'h3f};
            8'h56: g = {7'h1f, 7'h20, 7'h40, 7'h20, 7'h1f};
            8'h57: g = {7'h3f, 7'h40, 7'h38, 7'h40, 7'h3f};
            8'h58: g = {7'h63, 7'h14, 7'h08, 7'h14, 7'h63};
            8'h59: g = {7'h07, 7'h08, 7'h70, 7'h08, 7'h07};
            8'h5a: g = {7'h61, 7'h51, 7'h49, 7'h45, 7'h43};
            8'h2f: g = {7'h20, 7'h10, 7'h08, 7'h04, 7'h02}; // slash
            8'h2e: g = {7'h00, 7'h60, 7'h60, 7'h00, 7'h00}; // dot
            8'h2d: g = {7'h08, 7'h08, 7'h08, 7'h08, 7'h08}; // dash
            8'h5f: g = {7'h40, 7'h40, 7'h40, 7'h40, 7'h40}; // underscore
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

/* rtl/tovl_text_lit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tovl_text_lit: glyph dot test for one text string
// Maps a screen coordinate into a scaled character cell and looks up its dot.
// ----------------------------------------------------------------------------
module tovl_text_lit
    import tovl_pkg::*;
#(
    parameter int CHARS_MAX  = 8,
    parameter int LEFT_EDGE  = 32,
    parameter int TOP_EDGE   = 80,
    parameter int SCALE_LOG2 = 2
) (
    input  logic [11:0]              i_x,
    input  logic [11:0]              i_y,
    input  logic [CHARS_MAX*8-1:0]   i_text,
    input  logic [4:0]               i_length,
    output logic                     o_lit
);

    localparam int U_W   = 12 - SCALE_LOG2;
    localparam int IDX_W = (CHARS_MAX > 1) ? $clog2(CHARS_MAX) : 1;

    logic [11:0]      w_rx;
    logic [11:0]      w_ry;
    logic             w_in_org;
    logic [4:0]       w_len_sat;
    logic [7:0]       w_span;
    logic [U_W-1:0]   w_u;
    logic [U_W-1:0]   w_gy_full;
    logic             w_in_rows;
    logic             w_in_cols;
    logic [6:0]       w_u7;
    logic [12:0]      w_prod;
    logic [4:0]       w_q;
    logic [IDX_W-1:0] w_idx;
    logic [6:0]       w_rem;
    logic [2:0]       w_gx;
    logic [2:0]       w_gy;
    logic [7:0]       w_char;
    t_glyph           w_glyph;
    logic             w_dot;

    assign w_in_org  = (i_x >= 12'(LEFT_EDGE)) && (i_y >= 12'(TOP_EDGE));
    assign w_rx      = i_x - 12'(LEFT_EDGE);
    assign w_ry      = i_y - 12'(TOP_EDGE);
    assign w_len_sat = (i_length > 5'(CHARS_MAX)) ? 5'(CHARS_MAX) : i_length;
    assign w_span    = 8'(w_len_sat) * 8'd6;

    // font-pixel coordinates: drop the scale bits
    assign w_u       = w_rx[11:SCALE_LOG2];
    assign w_gy_full = w_ry[11:SCALE_LOG2];
    assign w_in_rows = (w_gy_full < U_W'(7));
    assign w_in_cols = (12'(w_u) < 12'(w_span));

    // divide by the 6-dot pitch: u*43 >> 8 is exact below 96
    assign w_u7   = w_u[6:0];
    assign w_prod = 13'(w_u7) * 13'd43;
    assign w_q    = w_prod[12:8];
    assign w_idx  = w_q[IDX_W-1:0];
    assign w_rem  = w_u7 - (7'(w_q) * 7'd6);
    assign w_gx   = w_rem[2:0];
    assign w_gy   = w_gy_full[2:0];

    assign w_char  = i_text[8*w_idx +: 8];
    assign w_glyph = glyph_lookup(w_char);

    // the gap column is never lit
    assign w_dot = (w_gx < 3'd5) ? w_glyph[w_gx][w_gy] : 1'b0;
    assign o_lit = w_in_org && w_in_rows && w_in_cols && w_dot;

endmodule

/* rtl/text_overlay_pixel_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_overlay_pixel_generator: two-string 5x7 text overlay
// Returns the RGB565 colour of each screen coordinate with text drawn on top.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data): one beat per pixel
//   coordinate. Output channel (o_out_valid / i_out_stall / o_out_data): one
//   beat per input beat, in order, with the pixel colour and a text flag.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//   always ready; write registers only while no pixel is in flight.
//   Path: an accepted input beat reaches its output beat through the input
//   register, then the result register.
//   Throughput: one pixel per cycle unless the output stalls, set by the
//   two-stage register pipeline; all glyph math sits between the two stages.
//   Reset: pipeline empties and all configuration registers clear, so the
//   screen is black background with no text.
//   Stall: a stalled output beat holds; an empty input register takes one
//   more input beat, then o_in_stall rises until the output drains.
// ----------------------------------------------------------------------------
module text_overlay_pixel_generator
    import tovl_pkg::*;
#(
    parameter int CODE_CHARS_MAX   = 8,
    parameter int DETAIL_CHARS_MAX = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_pixel_in   i_in_data,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_pixel_out  o_out_data,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    // configuration registers
    logic [15:0]  r_bg;
    logic [63:0]  r_code_text;
    logic [3:0]   r_code_len;
    logic [127:0] r_detail_text;
    logic [4:0]   r_detail_len;

    // pipeline registers
    logic       r_in_valid;
    t_pixel_in  r_in;
    logic       r_out_valid;
    t_pixel_out r_out;

    logic       w_adv_out;
    logic       w_adv_in;
    logic       w_code_lit;
    logic       w_detail_lit;
    logic       w_lit;
    logic [6:0] w_sum;
    logic [15:0] w_fg;
    t_pixel_out n_out;

    assign o_cfg_ready = 1'b1;

    // Write the selected register; drop writes to unused indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg          <= '0;
            r_code_text   <= '0;
            r_code_len    <= '0;
            r_detail_text <= '0;
            r_detail_len  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BACKGROUND_COLOR: r_bg                  <= i_cfg_data[15:0];
                CFG_CODE_TEXT:        r_code_text           <= i_cfg_data;
                CFG_CODE_LENGTH:      r_code_len            <= i_cfg_data[3:0];
                CFG_DETAIL_TEXT_LOW:  r_detail_text[63:0]   <= i_cfg_data;
                CFG_DETAIL_TEXT_HIGH: r_detail_text[127:64] <= i_cfg_data;
                CFG_DETAIL_LENGTH:    r_detail_len          <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Advance the result stage when it is empty or being taken; advance the
    // input stage when it is empty or moving on.
    assign w_adv_out  = !r_out_valid || !i_out_stall;
    assign w_adv_in   = !r_in_valid || w_adv_out;
    assign o_in_stall = !w_adv_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_adv_in) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_in && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Test both strings for a lit dot
    tovl_text_lit #(
        .CHARS_MAX  (CODE_CHARS_MAX),
        .LEFT_EDGE  (CODE_LEFT),
        .TOP_EDGE   (CODE_TOP),
        .SCALE_LOG2 (CODE_SCALE_LOG2)
    ) u_code (
        .i_x      (r_in.x_position),
        .i_y      (r_in.y_position),
        .i_text   (r_code_text[CODE_CHARS_MAX*8-1:0]),
        .i_length ({1'b0, r_code_len}),
        .o_lit    (w_code_lit)
    );

    tovl_text_lit #(
        .CHARS_MAX  (DETAIL_CHARS_MAX),
        .LEFT_EDGE  (DETAIL_LEFT),
        .TOP_EDGE   (DETAIL_TOP),
        .SCALE_LOG2 (DETAIL_SCALE_LOG2)
    ) u_detail (
        .i_x      (r_in.x_position),
        .i_y      (r_in.y_position),
        .i_text   (r_detail_text[DETAIL_CHARS_MAX*8-1:0]),
        .i_length (r_detail_len),
        .o_lit    (w_detail_lit)
    );

    // Pick black text on a bright background, white text otherwise
    assign w_sum = 7'(r_bg[15:11]) + 7'(r_bg[10:5]) + 7'(r_bg[4:0]);
    assign w_fg  = (w_sum > BRIGHT_LIMIT) ? FG_DARK : FG_LIGHT;
    assign w_lit = w_code_lit || w_detail_lit;

    always_comb begin
        n_out.is_text     = w_lit;
        n_out.pixel_color = w_lit ? w_fg : r_bg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv_out) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_out && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Stall upstream only while a beat is parked in the input register
    a_stall_needs_parked_beat: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall)
    ) else $error("input stalled without a parked beat");

    // An accepted input beat lands in the input register
    a_accept_lands: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_in_valid
    ) else $error("accepted beat lost at input stage");

    // A beat in the input register moves on when the result stage is empty
    a_empty_result_fills: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |=> o_out_valid
    ) else $error("beat did not reach the result stage");

endmodule

/* sim/tb_text_overlay_pixel_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_overlay_pixel_generator: self-checking bench for the text overlay
// Feeds screen coordinates through the pixel channel under random sender gaps
// and receiver stalls. A local model of both strings and the 5x7 font predicts
// each pixel colour and text flag. The bench reprograms all registers between
// phases, covering saturated, zero and in-range lengths, both foreground
// choices and writes to unused register indexes.
// ----------------------------------------------------------------------------
module tb_text_overlay_pixel_generator;
    import tovl_pkg::*;

    localparam int CODE_CHARS_MAX   = 8;
    localparam int DETAIL_CHARS_MAX = 16;
    localparam int GLYPH_COLS       = 5;
    localparam int GLYPH_ROWS       = 7;
    localparam int GLYPH_PITCH      = 6;
    // Two-stage pipeline; leave a few spare cycles before touching registers
    localparam int SETTLE_CYCLES    = 6;
    localparam int RANDOM_PHASES    = 6;
    localparam int BEATS_PER_PHASE  = 84;

    // Indexes past the last register; writes there must change nothing
    localparam logic [2:0] CFG_SPARE_A = 3'd6;
    localparam logic [2:0] CFG_SPARE_B = 3'd7;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        in_valid  = 1'b0;
    logic        in_stall;
    t_pixel_in   in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_pixel_out  out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data  = '0;

    // Register shadow for the colour predictor
    logic [15:0] bg_color;
    logic [63:0] code_text;
    logic [3:0]  code_len;
    logic [63:0] detail_lo;
    logic [63:0] detail_hi;
    logic [4:0]  detail_len;

    t_pixel_in   coords_todo[$];
    t_pixel_out  colors_due[$];
    t_pixel_out  want;
    logic        in_taken      = 1'b0;
    bit          sender_hold   = 1'b0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned mismatch_count = 0;

    text_overlay_pixel_generator #(
        .CODE_CHARS_MAX   (CODE_CHARS_MAX),
        .DETAIL_CHARS_MAX (DETAIL_CHARS_MAX)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Font: five column bytes per glyph, column 0 in the top byte, bit 0 of a
    // column is the top row. Lower case folds to upper case; anything without
    // a glyph (control bytes, bytes 0x80 and up, most punctuation) is blank.
    // ------------------------------------------------------------------------
    function automatic logic [6:0] font_column(input logic [7:0] ch, input int unsigned col);
        logic [7:0]  up;
        logic [39:0] cols;
        up = (ch >= "a" && ch <= "z") ? ch - 8'h20 : ch;
        case (up)
            "0": cols = 40'h3e_51_49_45_3e;
            "1": cols = 40'h00_42_7f_40_00;
            "2": cols = 40'h42_61_51_49_46;
            "3": cols = 40'h21_41_45_4b_31;
            "4": cols = 40'h18_14_12_7f_10;
            "5": cols = 40'h27_45_45_45_39;
            "6": cols = 40'h3c_4a_49_49_30;
            "7": cols = 40'h01_71_09_05_03;
            "8": cols = 40'h36_49_49_49_36;
            "9": cols = 40'h06_49_49_29_1e;
            "A": cols = 40'h7e_11_11_11_7e;
            "B": cols = 40'h7f_49_49_49_36;
            "C": cols = 40'h3e_41_41_41_22;
            "D": cols = 40'h7f_41_41_22_1c;
            "E": cols = 40'h7f_49_49_49_41;
            "F": cols = 40'h7f_09_09_09_01;
            "G": cols = 40'h3e_41_49_49_7a;
            "H": cols = 40'h7f_08_08_08_7f;
            "I": cols = 40'h00_41_7f_41_00;
            "J": cols = 40'h20_40_41_3f_01;
            "K": cols = 40'h7f_08_14_22_41;
            "L": cols = 40'h7f_40_40_40_40;
            "M": cols = 40'h7f_02_0c_02_7f;
            "N": cols = 40'h7f_04_08_10_7f;
            "O": cols = 40'h3e_41_41_41_3e;
            "P": cols = 40'h7f_09_09_09_06;
            "Q": cols = 40'h3e_41_51_21_5e;
            "R": cols = 40'h7f_09_19_29_46;
            "S": cols = 40'h46_49_49_49_31;
            "T": cols = 40'h01_01_7f_01_01;
            "U": cols = 40'h3f_40_40_40_3f;
            "V": cols = 40'h1f_20_40_20_1f;
            "W": cols = 40'h3f_40_38_40_3f;
            "X": cols = 40'h63_14_08_14_63;
            "Y": cols = 40'h07_08_70_08_07;
            "Z": cols = 40'h61_51_49_45_43;
            "/": cols = 40'h20_10_08_04_02;
            ".": cols = 40'h00_60_60_00_00;
            "-": cols = 40'h08_08_08_08_08;
            "_": cols = 40'h40_40_40_40_40;
            default: cols = '0;
        endcase
        if (col >= GLYPH_COLS) begin
            return '0;
        end
        return cols[32 - 8 * col +: 7];
    endfunction

    // Is (x, y) a lit dot of one string? Cells are GLYPH_PITCH font pixels
    // wide, the last column of each cell is the blank gap.
    function automatic bit text_hit(input bit is_detail, input int unsigned len,
                                    input int unsigned ox, input int unsigned oy,
                                    input int unsigned scale,
                                    input int unsigned x, input int unsigned y);
        int unsigned rx, ry, pitch, idx, gx, gy;
        logic [63:0] word;
        logic [6:0]  column;
        if (x < ox || y < oy) begin
            return 1'b0;
        end
        rx    = x - ox;
        ry    = y - oy;
        pitch = GLYPH_PITCH * scale;
        if (ry >= GLYPH_ROWS * scale || rx >= len * pitch) begin
            return 1'b0;
        end
        idx = rx / pitch;
        gx  = (rx % pitch) / scale;
        gy  = ry / scale;
        if (is_detail) begin
            word = (idx >= 8) ? detail_hi : detail_lo;
        end else begin
            word = code_text;
        end
        column = font_column(word[8 * (idx % 8) +: 8], gx);
        return column[gy];
    endfunction

    // Colour of one pixel under the current register shadow
    function automatic t_pixel_out overlay_color(input t_pixel_in px);
        int unsigned clen, dlen, brightness;
        logic [15:0] fg;
        bit          lit;
        t_pixel_out  res;
        // lengths past the string capacity saturate
        clen = (code_len > CODE_CHARS_MAX) ? CODE_CHARS_MAX : code_len;
        dlen = (detail_len > DETAIL_CHARS_MAX) ? DETAIL_CHARS_MAX : detail_len;
        lit  = text_hit(1'b0, clen, CODE_LEFT, CODE_TOP, 1 << CODE_SCALE_LOG2,
                        px.x_position, px.y_position) ||
               text_hit(1'b1, dlen, DETAIL_LEFT, DETAIL_TOP,
                        1 << DETAIL_SCALE_LOG2, px.x_position, px.y_position);
        brightness = bg_color[15:11] + bg_color[10:5] + bg_color[4:0];
        fg = (brightness > BRIGHT_LIMIT) ? FG_DARK : FG_LIGHT;
        res.pixel_color = lit ? fg : bg_color;
        res.is_text     = lit;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] exp);
        $display("ERROR %0t: %s got %h, expected %h", $time, what, got, exp);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: advance at the falling edge. A beat stays on the bus until the
    // rising edge that takes it; the next one goes out on a later falling edge.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid  <= 1'b0;
            out_stall <= 1'b0;
        end else begin
            if (!in_valid || in_taken) begin
                if (coords_todo.size() != 0 && !sender_hold &&
                    $urandom_range(99) >= send_idle_pct) begin
                    in_data  <= coords_todo.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: at each rising edge record the accepted pixel beat with its
    // predicted colour, then check any output beat against the oldest one.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        in_taken <= in_valid && !in_stall;
        if (i_rst_n) begin
            if (in_valid && !in_stall) begin
                colors_due.push_back(overlay_color(in_data));
            end
            if (out_valid && !out_stall) begin
                if (colors_due.size() == 0) begin
                    report_mismatch("unexpected beat, colour", out_data.pixel_color, '0);
                end else begin
                    want = colors_due.pop_front();
                    if (out_data.pixel_color !== want.pixel_color) begin
                        report_mismatch("pixel_color", out_data.pixel_color,
                                        want.pixel_color);
                    end
                    if (out_data.is_text !== want.is_text) begin
                        report_mismatch("is_text", 16'(out_data.is_text), 16'(want.is_text));
                    end
                end
            end
        end
    end

    // Write one register; leave valid high so back-to-back writes never lower
    // and raise it in the same step. The caller drops valid after the last one.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(posedge i_clk);
        end while (!cfg_ready);
        case (idx)
            CFG_BACKGROUND_COLOR: bg_color   = val[15:0];
            CFG_CODE_TEXT:        code_text  = val;
            CFG_CODE_LENGTH:      code_len   = val[3:0];
            CFG_DETAIL_TEXT_LOW:  detail_lo  = val;
            CFG_DETAIL_TEXT_HIGH: detail_hi  = val;
            CFG_DETAIL_LENGTH:    detail_len = val[4:0];
            default: ;
        endcase
    endtask

    task automatic load_setting(input logic [15:0] bg, input logic [63:0] code,
                                input logic [63:0] clen, input logic [63:0] dlo,
                                input logic [63:0] dhi, input logic [63:0] dlen);
        write_reg(CFG_BACKGROUND_COLOR, 64'(bg));
        write_reg(CFG_SPARE_A, {$urandom, $urandom});
        write_reg(CFG_CODE_TEXT, code);
        write_reg(CFG_CODE_LENGTH, clen);
        write_reg(CFG_DETAIL_TEXT_LOW, dlo);
        write_reg(CFG_DETAIL_TEXT_HIGH, dhi);
        write_reg(CFG_DETAIL_LENGTH, dlen);
        write_reg(CFG_SPARE_B, {$urandom, $urandom});
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Hold until every queued pixel has gone in and every colour has come out
    task automatic wait_drained();
        while (coords_todo.size() != 0 || in_valid || colors_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_pixel(input int unsigned x, input int unsigned y);
        t_pixel_in px;
        px.x_position = x[11:0];
        px.y_position = y[11:0];
        coords_todo.push_back(px);
    endtask

    // Mostly glyph characters, with a share of arbitrary bytes (blank cells,
    // zero bytes, bytes 0x80 and up)
    function automatic logic [7:0] rand_char();
        case ($urandom_range(9))
            0, 1: return 8'("0" + $urandom_range(9));
            2, 3: return 8'("A" + $urandom_range(25));
            4:    return 8'("a" + $urandom_range(25));
            5: begin
                case ($urandom_range(3))
                    0: return "/";
                    1: return ".";
                    2: return "-";
                    default: return "_";
                endcase
            end
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [63:0] rand_text();
        logic [63:0] word;
        for (int i = 0; i < 8; i++) begin
            word[8 * i +: 8] = rand_char();
        end
        return word;
    endfunction

    // Coordinates: most land in or near the two text bands, the rest anywhere
    function automatic t_pixel_in rand_pixel();
        t_pixel_in   px;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 35) begin
            px.x_position = 12'($urandom_range(24, 232));
            px.y_position = 12'($urandom_range(74, 114));
        end else if (pick < 70) begin
            px.x_position = 12'($urandom_range(24, 232));
            px.y_position = 12'($urandom_range(154, 180));
        end else begin
            px.x_position = 12'($urandom);
            px.y_position = 12'($urandom);
        end
        return px;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [15:0] bg;
        logic [63:0] clen, dlen;

        bg_color   = '0;
        code_text  = '0;
        code_len   = '0;
        detail_lo  = '0;
        detail_hi  = '0;
        detail_len = '0;

        send_idle_pct = 26;
        recv_idle_pct = 68;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Defaults after reset: black background, no text anywhere
        queue_pixel(32, 84);
        queue_pixel(0, 0);
        queue_pixel(4095, 4095);
        wait_drained();

        // Directed: white background so lit dots come out black. Code string
        // "A0/._-zq" exercises every punctuation glyph and case folding; the
        // detail string carries a zero byte, bytes 0x80/0xff and a '!' blank.
        load_setting(16'hffff, 64'h71_7a_2d_5f_2e_2f_30_41, 64'd8,
                     64'h35_21_ff_80_00_6d_5a_39, 64'h2d_2e_5f_6b_2f_59_58_57, 64'd16);
        queue_pixel(0, 0);
        queue_pixel(4095, 4095);
        queue_pixel(4095, 0);
        queue_pixel(0, 4095);
        queue_pixel(32, 80);        // code origin, top row of 'A' is unlit
        queue_pixel(32, 84);        // 'A' first column, second row
        queue_pixel(35, 107);       // 'A' bottom row, last scaled pixel
        queue_pixel(32, 108);       // just below the code band
        queue_pixel(31, 84);        // just left of the code origin
        queue_pixel(52, 84);        // gap column after the first character
        queue_pixel(56, 84);        // second character starts
        queue_pixel(216, 100);      // last code character, last glyph column
        queue_pixel(223, 100);      // last pixel of the code band
        queue_pixel(224, 100);      // one past the code string
        queue_pixel(32, 162);       // detail origin, '9'
        queue_pixel(68, 162);       // zero byte cell stays blank
        queue_pixel(82, 164);       // byte 0x80 cell stays blank
        queue_pixel(220, 166);      // last detail character, last column
        queue_pixel(224, 166);      // one past the detail string
        queue_pixel(42, 166);       // detail gap column
        queue_pixel(128, 172);      // upper detail word, bottom glyph row
        queue_pixel(128, 174);      // just below the detail band
        wait_drained();

        // Random phases, each with its own register setting
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 2) begin
                send_idle_pct = 68;
                recv_idle_pct = 26;
            end else if (phase == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (phase)
                0: begin
                    // brightness exactly at the limit keeps white; lengths saturate
                    bg   = 16'hfc00;
                    clen = 64'd15;
                    dlen = 64'd31;
                end
                1: begin
                    // one step above the limit flips to black; both strings empty
                    bg   = 16'hfc20;
                    clen = 64'd0;
                    dlen = 64'd0;
                end
                2: begin
                    bg   = 16'h0000;
                    clen = 64'($urandom_range(1, 15));
                    dlen = 64'($urandom_range(1, 31));
                end
                3: begin
                    // junk above the length fields must be dropped
                    bg   = 16'($urandom);
                    clen = {$urandom, $urandom};
                    dlen = {$urandom, $urandom};
                end
                4: begin
                    bg   = 16'hffff;
                    clen = 64'd8;
                    dlen = 64'd16;
                end
                default: begin
                    bg   = 16'($urandom);
                    clen = 64'($urandom_range(0, 15));
                    dlen = 64'($urandom_range(0, 31));
                end
            endcase
            load_setting(bg, rand_text(), clen, rand_text(), rand_text(), dlen);

            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                coords_todo.push_back(rand_pixel());
            end

            // Once, pause the sender mid-phase until the pipeline is empty
            if (phase == 2) begin
                while (coords_todo.size() > BEATS_PER_PHASE / 2) @(posedge i_clk);
                sender_hold = 1'b1;
                while (in_valid || colors_due.size() != 0) @(posedge i_clk);
                repeat (3) @(posedge i_clk);
                sender_hold = 1'b0;
            end
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("tb_text_overlay_pixel_generator passed");
        end else begin
            $display("tb_text_overlay_pixel_generator failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("tb_text_overlay_pixel_generator failed");
        $finish;
    end

endmodule
